// ===== rtl/sfsf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfsf_pkg
// Shared constants, codes and types of the smallest-factor sieve factorizer.
// ---------------------------------------------------------------------------
package sfsf_pkg;

    localparam int unsigned MAX_LIMIT_DEF   = 1048575;
    localparam int unsigned PRIME_SLOTS_DEF = 82025;

    localparam int unsigned VALUE_W  = 20;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned EXP_W    = 5;
    localparam int unsigned COUNT_W  = 17;
    localparam int unsigned RES_W    = 3;   // result index inside one item
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 48;

    localparam logic [0:0] OP_BUILD  = 1'b0;
    localparam logic [0:0] OP_FACTOR = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_B_RD,
        S_B_CHK,
        S_B_PR,
        S_B_MUL,
        S_B_WR,
        S_B_NEXT,
        S_F_RD,
        S_F_CHK,
        S_F_START,
        S_F_DIV,
        S_OUT
    } state_t;

endpackage

// ===== rtl/sfsf_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sfsf_div
// Restoring divider, one quotient bit per cycle; done pulses when the last quotient bit is in.
// ---------------------------------------------------------------------------
module sfsf_div import sfsf_pkg::*; #(
    parameter int unsigned W = 20
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quot,
    output logic [W-1:0] rem
);

    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    trial;

    // Try to subtract the divisor from the shifted partial remainder
    always_comb begin
        trial = {rem_reg, quo_reg[W-1]} - {1'b0, dsr_reg};
        if (!trial[W]) begin
            rem_next = trial[W-1:0];
            quo_next = {quo_reg[W-2:0], 1'b1};
        end else begin
            rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
            quo_next = {quo_reg[W-2:0], 1'b0};
        end
    end

    // Control: count W steps after start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CW'(W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Datapath: load operands, then shift one bit a cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/smallest_factor_sieve_factorizer_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smallest_factor_sieve_factorizer_top
// Linear sieve of smallest prime factors held in block memory, plus a
// factorizer that walks the table and splits off each prime power.
// ---------------------------------------------------------------------------
// Channel   Direction  Word contents
// s_        in         tuser: opcode; tdata[19:0]: value
// m_        out        tdata: status, prime_factor, exponent, prime_count;
//                      tlast: last result of the item
// limit     cfg        sieve_limit_wr_en / sieve_limit_wr_data[19:0]
//
// Build: table clear from 0 to the limit, then per value a read and a check,
//   plus a multiply and a write per prime tried in the inner loop, on the single table port.
// Factor: one division per prime power plus one more per prime, on the
//   W-bit divider (W = 20 at default size).
// One item at a time; s_tready is high only while idle. Each result waits
//   in the output register until taken. Reset leaves the table unbuilt.
// ---------------------------------------------------------------------------
module smallest_factor_sieve_factorizer_top import sfsf_pkg::*; #(
    parameter int unsigned MAX_LIMIT   = MAX_LIMIT_DEF,
    parameter int unsigned PRIME_SLOTS = PRIME_SLOTS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   sieve_limit_wr_en,
    input  logic [VALUE_W-1:0]     sieve_limit_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [19:0] value, rest zero
    input  logic [0:0]             s_tuser,   // [0] opcode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [1:0] status, [21:2] prime_factor,
                                              // [26:22] exponent, [43:27] prime_count
    output logic                   m_tlast
);

    localparam int unsigned AW = $clog2(MAX_LIMIT + 1);
    localparam int unsigned NW = (AW > VALUE_W) ? AW : VALUE_W;
    localparam int unsigned PW = $clog2(PRIME_SLOTS);
    localparam int unsigned CW = $clog2(PRIME_SLOTS + 1);

    // Memories
    logic [AW-1:0] spf_mem   [0:MAX_LIMIT];
    logic [AW-1:0] plist_mem [0:PRIME_SLOTS-1];

    state_t state_reg, state_next;

    logic [VALUE_W-1:0] limit_reg;
    logic [NW-1:0]      lim_reg;
    logic [NW-1:0]      built_reg;
    logic [CW-1:0]      count_reg;
    logic [NW-1:0]      i_reg;
    logic [NW-1:0]      spfi_reg;
    logic [CW-1:0]      j_reg;
    logic [NW-1:0]      p_reg;
    logic [2*NW-1:0]    prod_reg;
    logic [NW-1:0]      v_reg;
    logic [EXP_W-1:0]   e_reg;
    logic [RES_W-1:0]   k_reg;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [VALUE_W-1:0]  pf_reg;
    logic [EXP_W-1:0]    ex_reg;
    logic [COUNT_W-1:0]  pc_reg;
    logic                last_reg;

    logic [AW-1:0] tbl_q;
    logic [AW-1:0] pl_q;
    logic          tbl_we;
    logic [AW-1:0] tbl_waddr;
    logic [AW-1:0] tbl_wdata;
    logic [AW-1:0] tbl_raddr;

    logic          div_start;
    logic          div_done;
    logic [NW-1:0] div_q;
    logic [NW-1:0] div_r;

    logic [NW-1:0]       lim_eff;
    logic [NW-1:0]       in_value;
    logic [NW-1:0]       tbl_ext;
    logic [NW-1:0]       p_pick;
    logic                s_acc;
    logic                m_acc;
    logic [CW+COUNT_W-1:0] count_wide;

    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_valid_reg && m_tready;
    assign in_value = NW'(s_tdata[VALUE_W-1:0]);
    assign tbl_ext  = NW'(tbl_q);
    assign count_wide = (CW + COUNT_W)'(count_reg);

    // Clamp the configured limit to the table range
    always_comb begin
        lim_eff = NW'(limit_reg);
        if (lim_eff < NW'(2)) begin
            lim_eff = NW'(2);
        end else if (lim_eff > NW'(MAX_LIMIT)) begin
            lim_eff = NW'(MAX_LIMIT);
        end
    end

    // Take the stored factor unless it is broken
    always_comb begin
        p_pick = tbl_ext;
        if (tbl_ext < NW'(2) || tbl_ext > v_reg) begin
            p_pick = v_reg;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    if (s_tuser == OP_BUILD) begin
                        state_next = S_CLR;
                    end else if (built_reg == '0 || in_value == '0
                                 || in_value > built_reg || in_value == NW'(1)) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_F_RD;
                    end
                end
            end
            S_CLR: begin
                if (i_reg == lim_reg) begin
                    state_next = S_B_RD;
                end
            end
            S_B_RD:  state_next = S_B_CHK;
            S_B_CHK: state_next = S_B_PR;
            S_B_PR: begin
                if (j_reg < count_reg) begin
                    state_next = S_B_MUL;
                end else begin
                    state_next = S_B_NEXT;
                end
            end
            S_B_MUL: state_next = S_B_WR;
            S_B_WR: begin
                if (prod_reg > (2*NW)'(lim_reg) || p_reg == spfi_reg) begin
                    state_next = S_B_NEXT;
                end else begin
                    state_next = S_B_PR;
                end
            end
            S_B_NEXT: begin
                if (i_reg == lim_reg) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_B_RD;
                end
            end
            S_F_RD:    state_next = S_F_CHK;
            S_F_CHK:   state_next = S_F_START;
            S_F_START: state_next = S_F_DIV;
            S_F_DIV: begin
                if (div_done) begin
                    if (div_r == '0) begin
                        state_next = S_F_START;
                    end else begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (m_acc) begin
                    if (last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_F_RD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory ports and divider start
    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = i_reg[AW-1:0];
        tbl_wdata = '0;
        tbl_raddr = i_reg[AW-1:0];
        div_start = 1'b0;
        s_tready  = 1'b0;
        unique case (state_reg)
            S_IDLE: s_tready = 1'b1;
            S_CLR: begin
                tbl_we    = 1'b1;
                tbl_wdata = (i_reg == NW'(1)) ? AW'(1) : '0;
            end
            S_B_CHK: begin
                tbl_we    = (tbl_q == '0);
                tbl_wdata = i_reg[AW-1:0];
            end
            S_B_WR: begin
                tbl_we    = !(prod_reg > (2*NW)'(lim_reg));
                tbl_waddr = prod_reg[AW-1:0];
                tbl_wdata = p_reg[AW-1:0];
            end
            S_F_RD:    tbl_raddr = v_reg[AW-1:0];
            S_F_START: div_start = 1'b1;
            default: ;
        endcase
    end

    // Smallest-factor table: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            spf_mem[tbl_waddr] <= tbl_wdata;
        end
        tbl_q <= spf_mem[tbl_raddr];
    end

    // Prime list: append on a new prime, read at the inner index
    always_ff @(posedge aclk) begin
        if (state_reg == S_B_CHK && tbl_q == '0 && count_reg < CW'(PRIME_SLOTS)) begin
            plist_mem[count_reg[PW-1:0]] <= i_reg[AW-1:0];
        end
        pl_q <= plist_mem[j_reg[PW-1:0]];
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= VALUE_W'(MAX_LIMIT_DEF);
        end else if (sieve_limit_wr_en) begin
            limit_reg <= sieve_limit_wr_data;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            built_reg   <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && s_acc && s_tuser == OP_BUILD) begin
                count_reg <= '0;
            end
            if (state_reg == S_B_CHK && tbl_q == '0 && count_reg < CW'(PRIME_SLOTS)) begin
                count_reg <= count_reg + 1'b1;
            end
            if (state_reg == S_B_NEXT && i_reg == lim_reg) begin
                built_reg <= lim_reg;
            end
            if (state_next == S_OUT && state_reg != S_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_acc) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                lim_reg <= lim_eff;
                i_reg   <= '0;
                v_reg   <= in_value;
                k_reg   <= '0;
                pf_reg  <= '0;
                ex_reg  <= '0;
                pc_reg  <= '0;
                last_reg <= 1'b1;
                if (built_reg == '0) begin
                    st_reg <= ST_NOT_BUILT;
                end else if (in_value == '0 || in_value > built_reg) begin
                    st_reg <= ST_RANGE;
                end else begin
                    st_reg <= ST_OK;
                end
            end
            S_CLR: begin
                if (i_reg == lim_reg) begin
                    i_reg <= NW'(2);
                end else begin
                    i_reg <= i_reg + 1'b1;
                end
            end
            S_B_CHK: begin
                spfi_reg <= (tbl_q == '0) ? i_reg : tbl_ext;
                j_reg    <= '0;
            end
            S_B_MUL: begin
                p_reg    <= NW'(pl_q);
                prod_reg <= NW'(pl_q) * i_reg;
            end
            S_B_WR: begin
                j_reg <= j_reg + 1'b1;
            end
            S_B_NEXT: begin
                i_reg <= i_reg + 1'b1;
                if (i_reg == lim_reg) begin
                    st_reg   <= ST_OK;
                    pf_reg   <= '0;
                    ex_reg   <= '0;
                    pc_reg   <= count_wide[COUNT_W-1:0];
                    last_reg <= 1'b1;
                end
            end
            S_F_CHK: begin
                p_reg <= p_pick;
                e_reg <= '0;
            end
            S_F_DIV: begin
                if (div_done) begin
                    if (div_r == '0) begin
                        v_reg <= div_q;
                        e_reg <= e_reg + 1'b1;
                    end else begin
                        st_reg   <= ST_OK;
                        pf_reg   <= p_reg[VALUE_W-1:0];
                        ex_reg   <= e_reg;
                        pc_reg   <= '0;
                        last_reg <= (v_reg <= NW'(1)) || (k_reg == '1);
                    end
                end
            end
            S_OUT: begin
                if (m_acc) begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    sfsf_div #(
        .W(NW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (v_reg),
        .divisor  (p_reg),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    // Drive the result word
    assign m_tvalid = m_valid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {4'd0, pc_reg, ex_reg, pf_reg, st_reg};

    // Input is taken only while no result is pending
    assert property (@(posedge aclk) disable iff (!aresetn) s_tready |-> !m_tvalid)
        else $error("input accepted while a result is pending");

    // Error results always end their item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1:0] != ST_OK) |-> m_tlast)
        else $error("error result without last");

    // A reported prime carries a nonzero exponent
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[21:2] != '0) |-> (m_tdata[26:22] != '0))
        else $error("prime reported with zero exponent");

    // The divider is never restarted while a division runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_F_DIV && !div_done) |=> !div_start || $past(div_done))
        else $error("divider restarted early");

endmodule
